[rtl/core/smed_pkg.sv]
// ----------------------------------------------------------------------------
// smed_pkg
// Shared types and defaults for the sliding window median unit.
// ----------------------------------------------------------------------------
package smed_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_W           = 7;

    typedef enum logic [0:0] {
        SMED_IDLE,
        SMED_DRAIN
    } smed_state_t;

    // one update of the chain
    typedef struct packed {
        logic drop;
        logic ins;
    } smed_op_t;

    // direction an entry moves in this update
    typedef struct packed {
        logic up;
        logic down;
    } smed_move_t;

endpackage

[rtl/core/smed_cell.sv]
// ----------------------------------------------------------------------------
// smed_cell
// One slot of the sorted window. Compares its entry against the new sample
// and the dropped value, and takes its next entry from itself, a neighbor or
// the new sample.
// ----------------------------------------------------------------------------
module smed_cell import smed_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int IDX_W       = 6,
    parameter int LEN_W       = 7,
    parameter int IDX         = 0
) (
    input  logic                          aclk,
    input  smed_op_t                      op,
    input  logic [LEN_W-1:0]              fill,
    input  logic [IDX_W-1:0]              oldest_age,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SAMPLE_BITS-1:0] v_drop,
    input  smed_move_t                    left_mv,
    input  logic signed [SAMPLE_BITS-1:0] left_val,
    input  logic [IDX_W-1:0]              left_age,
    input  smed_move_t                    right_mv,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  logic [IDX_W-1:0]              right_age,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic [IDX_W-1:0]              age,
    output smed_move_t                    mv,
    output logic                          kill
);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [IDX_W-1:0]              age_reg, age_next;
    logic                          valid, above_drop, above_new, stay;
    logic [IDX_W-1:0]              age_step;

    assign valid      = LEN_W'(IDX) < fill;
    assign kill       = op.drop && valid && (age_reg == oldest_age);
    assign above_drop = op.drop && valid && !kill && (val_reg >= v_drop);
    assign above_new  = op.ins && valid && (val_reg > x);
    assign mv.up      = valid && !kill && above_new && !above_drop;
    assign mv.down    = valid && !kill && above_drop && !above_new;
    assign stay       = valid && !kill && !mv.up && !mv.down;
    assign age_step   = IDX_W'(op.ins);

    always_comb begin
        if (right_mv.down) begin
            val_next = right_val;
            age_next = right_age + age_step;
        end else if (left_mv.up) begin
            val_next = left_val;
            age_next = left_age + age_step;
        end else if (stay) begin
            val_next = val_reg;
            age_next = age_reg + age_step;
        end else begin
            val_next = x;
            age_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.drop || op.ins) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

[rtl/core/sliding_window_median_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_unit
// Running lower median over the most recent window_length samples.
// ----------------------------------------------------------------------------
// Samples are kept in ascending order in a row of cells; each cell also
// holds the age of its entry, so the oldest is found locally and removed
// while the new sample is inserted in the same cycle. In steady state one
// sample is taken per clock while the output is not stalled; the chain
// and the pending rank are registered first, then the median is read into
// the output register. No result is produced before the window has filled
// to window_length samples. If window_length is lowered below the current
// fill, a request removes one surplus entry per unstalled clock, then inserts.
// ----------------------------------------------------------------------------
module sliding_window_median_unit import smed_pkg::*; #(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int DATA_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,   // window_length
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,       // sample
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata        // median
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    logic [CFG_W-1:0]              wlen_reg;
    logic [LEN_W-1:0]              len_act;
    logic [LEN_W-1:0]              fill_reg, fill_next;
    smed_state_t                   state_reg, state_next;
    logic signed [SAMPLE_BITS-1:0] hold_reg, x;
    logic                          hold_load;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]              pend_rank_reg;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_data_reg;
    logic                          can_advance, pend_free, accept, emit;
    logic                          over, at_len;
    smed_op_t                      op;
    logic [IDX_W-1:0]              oldest_age;
    logic signed [SAMPLE_BITS-1:0] v_drop;
    logic [LEN_W-1:0]              rank_full;

    logic signed [SAMPLE_BITS-1:0] cval [WINDOW_MAX];
    logic [IDX_W-1:0]              cage [WINDOW_MAX];
    smed_move_t                    cmv  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]         ckill;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            wlen_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        if (wlen_reg == '0) begin
            len_act = LEN_W'(1);
        end else if (int'(wlen_reg) > WINDOW_MAX) begin
            len_act = LEN_W'(WINDOW_MAX);
        end else begin
            len_act = LEN_W'(wlen_reg);
        end
    end

    assign can_advance = !out_valid_reg || m_tready;
    assign pend_free   = !pend_valid_reg || can_advance;
    assign s_tready    = (state_reg == SMED_IDLE) && pend_free;
    assign accept      = s_tvalid && s_tready;
    assign over        = fill_reg > len_act;
    assign at_len      = fill_reg == len_act;
    assign x           = (state_reg == SMED_DRAIN) ? hold_reg
                                                   : $signed(s_tdata[SAMPLE_BITS-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SMED_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op         = '0;
        hold_load  = 1'b0;
        case (state_reg)
            SMED_IDLE: begin
                if (accept) begin
                    if (over) begin
                        op.drop    = 1'b1;
                        hold_load  = 1'b1;
                        state_next = SMED_DRAIN;
                    end else begin
                        op.drop = at_len;
                        op.ins  = 1'b1;
                    end
                end
            end
            SMED_DRAIN: begin
                if (pend_free) begin
                    if (over) begin
                        op.drop = 1'b1;
                    end else begin
                        op.drop    = at_len;
                        op.ins     = 1'b1;
                        state_next = SMED_IDLE;
                    end
                end
            end
            default: begin
                state_next = SMED_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hold_load) begin
            hold_reg <= $signed(s_tdata[SAMPLE_BITS-1:0]);
        end
    end

    assign fill_next = fill_reg - LEN_W'(op.drop) + LEN_W'(op.ins);
    assign emit      = op.ins && (fill_next == len_act);
    assign rank_full = (len_act - LEN_W'(1)) >> 1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // cell chain
    assign oldest_age = IDX_W'(fill_reg - LEN_W'(1));

    always_comb begin
        v_drop = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (ckill[i]) begin
                v_drop = v_drop | cval[i];
            end
        end
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        smed_move_t                    l_mv, r_mv;
        logic signed [SAMPLE_BITS-1:0] l_val, r_val;
        logic [IDX_W-1:0]              l_age, r_age;

        if (i == 0) begin : g_left_end
            assign l_mv  = '0;
            assign l_val = '0;
            assign l_age = '0;
        end else begin : g_left
            assign l_mv  = cmv[i-1];
            assign l_val = cval[i-1];
            assign l_age = cage[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_right_end
            assign r_mv  = '0;
            assign r_val = '0;
            assign r_age = '0;
        end else begin : g_right
            assign r_mv  = cmv[i+1];
            assign r_val = cval[i+1];
            assign r_age = cage[i+1];
        end

        smed_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IDX_W       (IDX_W),
            .LEN_W       (LEN_W),
            .IDX         (i)
        ) u_cell (
            .aclk       (aclk),
            .op         (op),
            .fill       (fill_reg),
            .oldest_age (oldest_age),
            .x          (x),
            .v_drop     (v_drop),
            .left_mv    (l_mv),
            .left_val   (l_val),
            .left_age   (l_age),
            .right_mv   (r_mv),
            .right_val  (r_val),
            .right_age  (r_age),
            .val        (cval[i]),
            .age        (cage[i]),
            .mv         (cmv[i]),
            .kill       (ckill[i])
        );
    end

    // result pipeline: rank is registered at insertion and read from the chain once the output can advance
    always_comb begin
        if (can_advance) begin
            pend_valid_next = emit;
        end else begin
            pend_valid_next = pend_valid_reg || emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            if (can_advance) begin
                out_valid_reg <= pend_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pend_rank_reg <= IDX_W'(rank_full);
        end
        if (can_advance && pend_valid_reg) begin
            out_data_reg <= cval[pend_rank_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= WINDOW_MAX)
        else $error("fill count above window capacity");

    a_one_oldest: assert property (@(posedge aclk) disable iff (!aresetn)
        op.drop |-> $onehot(ckill))
        else $error("removal without exactly one oldest entry");

    a_drain_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SMED_DRAIN) |-> (fill_reg >= len_act))
        else $error("drain state with fill below window length");

    a_pend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && !can_advance) |-> (op.drop == 1'b0 && op.ins == 1'b0))
        else $error("chain updated while a result read is pending");

endmodule
